/* hw/rtl/hrta_pkg.sv */
package hrta_pkg;

    // Default width of the stored times. Time stamps on the input stay 32 bits.
    localparam int TIME_BITS_DEF = 32;

    localparam int IN_TIME_W  = 32;
    localparam int MAX_HITS_W = 8;
    localparam int DUR_W      = 8;
    localparam int GRACE_W    = 16;
    localparam int HITS_W     = 16;
    localparam int OVER_CNT_W = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [MAX_HITS_W-1:0] MAX_HITS_RST = '0;
    localparam logic [DUR_W-1:0]      DUR_RST      = '0;
    localparam logic [GRACE_W-1:0]    GRACE_RST    = GRACE_W'(60);

    // Register index, taken from the word address paddr[3:2].
    typedef enum logic [1:0] {
        REG_MAX_HITS = 2'd0,
        REG_OVER_DUR = 2'd1,
        REG_GRACE    = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MAX_HITS_W-1:0] max_hits_per_second;
        logic [DUR_W-1:0]      over_duration_seconds;
        logic [GRACE_W-1:0]    grace_period_seconds;
    } cfg_t;

endpackage

/* hw/rtl/hrta_cfg.sv */
module hrta_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hrta_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hrta_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hrta_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output hrta_pkg::cfg_t                      cfg
);
    import hrta_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MAX_HITS: cfg_next.max_hits_per_second   = pwdata[MAX_HITS_W-1:0];
                REG_OVER_DUR: cfg_next.over_duration_seconds = pwdata[DUR_W-1:0];
                REG_GRACE:    cfg_next.grace_period_seconds  = pwdata[GRACE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_HITS: prdata = APB_DATA_W'(cfg_reg.max_hits_per_second);
            REG_OVER_DUR: prdata = APB_DATA_W'(cfg_reg.over_duration_seconds);
            REG_GRACE:    prdata = APB_DATA_W'(cfg_reg.grace_period_seconds);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_hits_per_second   <= MAX_HITS_RST;
            cfg_reg.over_duration_seconds <= DUR_RST;
            cfg_reg.grace_period_seconds  <= GRACE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/hrta_core.sv */
module hrta_core
#(
    parameter int TIME_BITS = hrta_pkg::TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [TIME_BITS-1:0] hit_time,
    input  hrta_pkg::cfg_t       cfg,
    output logic                 alarm
);
    import hrta_pkg::*;

    logic [TIME_BITS-1:0]  last_hit_reg,  last_hit_next;
    logic [TIME_BITS-1:0]  last_over_reg, last_over_next;
    logic [OVER_CNT_W-1:0] over_cnt_reg,  over_cnt_next;
    logic [HITS_W-1:0]     hits_reg,      hits_next;
    logic                  latched_reg,   latched_next;

    logic [TIME_BITS:0]    grace_sum;
    logic [TIME_BITS-1:0]  grace_end;
    logic [TIME_BITS-1:0]  gap;
    logic [HITS_W-1:0]     max_hits_ext;
    logic                  absorb;

    assign grace_sum    = {1'b0, last_over_reg}
                        + (TIME_BITS+1)'(cfg.grace_period_seconds);
    assign grace_end    = grace_sum[TIME_BITS] ? '1 : grace_sum[TIME_BITS-1:0];
    assign absorb       = latched_reg && (hit_time < grace_end);
    assign gap          = hit_time - last_hit_reg;
    assign max_hits_ext = HITS_W'(cfg.max_hits_per_second);

    always_comb
    begin
        last_hit_next  = last_hit_reg;
        last_over_next = last_over_reg;
        over_cnt_next  = over_cnt_reg;
        hits_next      = hits_reg;
        latched_next   = latched_reg;

        if (absorb)
        begin
            alarm = 1'b1;
        end
        else
        begin
            latched_next = 1'b0;

            // A later second: either start over or carry the over-second run on.
            if (hit_time > last_hit_reg)
            begin
                if ((gap != TIME_BITS'(1)) || (hits_reg <= max_hits_ext))
                begin
                    last_hit_next  = '0;
                    last_over_next = '0;
                    over_cnt_next  = '0;
                    hits_next      = '0;
                end
                else
                begin
                    hits_next = '0;
                end
            end

            if (hits_next != '1)
            begin
                hits_next = hits_next + HITS_W'(1);
            end
            last_hit_next = hit_time;

            if ((hits_next > max_hits_ext) && (last_over_next < hit_time))
            begin
                if (over_cnt_next != '1)
                begin
                    over_cnt_next = over_cnt_next + OVER_CNT_W'(1);
                end
                last_over_next = hit_time;
                if (over_cnt_next > cfg.over_duration_seconds)
                begin
                    latched_next = 1'b1;
                end
            end

            alarm = latched_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_hit_reg  <= '0;
            last_over_reg <= '0;
            over_cnt_reg  <= '0;
            hits_reg      <= '0;
            latched_reg   <= 1'b0;
        end
        else if (step)
        begin
            last_hit_reg  <= last_hit_next;
            last_over_reg <= last_over_next;
            over_cnt_reg  <= over_cnt_next;
            hits_reg      <= hits_next;
            latched_reg   <= latched_next;
        end
    end

endmodule

/* hw/rtl/hit_rate_threshold_alarm_unit.sv */
// Hit-rate alarm with hold-off. Every input transfer carries one hit time in
// whole seconds and yields exactly one output transfer carrying the alarm bit.
// The block counts hits per second, counts consecutive seconds whose hit count
// exceeds max_hits_per_second, and raises the alarm once that run exceeds
// over_duration_seconds; after that, hits that arrive before the last over
// second plus grace_period_seconds report alarm without touching the counters.
// Throughput is one hit per clock while the output is not stalled: a hit waits
// in the input register, is evaluated against the state in a single
// compare-and-update step, and its result lands in the output register. The output
// register decouples the two sides, and input is taken whenever that register
// is empty or being drained. Configuration registers (APB, byte addresses 0x0,
// 0x4, 0x8) should only be written while no hits are in flight.
module hit_rate_threshold_alarm_unit
#(
    parameter int TIME_BITS = hrta_pkg::TIME_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    // Input stream. tdata[31:0] = hit_time_seconds.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [hrta_pkg::IN_TIME_W-1:0]   s_axis_tdata,

    // Output stream. tdata[0] = alarm, tdata[7:1] = zero.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,

    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hrta_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hrta_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hrta_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import hrta_pkg::*;

    cfg_t                 cfg;

    // Input register holding one accepted hit.
    logic                 in_valid_reg;
    logic [TIME_BITS-1:0] in_time_reg;

    // Output register holding one finished result.
    logic                 out_valid_reg;
    logic                 out_alarm_reg;
    logic                 alarm_next;

    logic                 advance;
    logic                 in_take;

    // The held hit moves on when the output register is free or is being read
    // in this cycle; a new hit can enter whenever the input register empties.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_alarm_reg};

    hrta_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The state updates only when the hit's result is written out, so each
    // hit sees the state left by the one before it.
    hrta_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .hit_time (in_time_reg),
        .cfg      (cfg),
        .alarm    (alarm_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_time_reg <= TIME_BITS'(s_axis_tdata);
        end
        if (advance)
        begin
            out_alarm_reg <= alarm_next;
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import hrta_pkg::*;

    // Scoreboard: it keeps a copy of the register file and of the per-second
    // counters. Each hit accepted on the input stream is run through that copy,
    // and the alarm bit that hit must produce is queued. Alarm transfers from the
    // block are checked against the head of the queue, in order.
    class alarm_scoreboard;
        bit [MAX_HITS_W-1:0] cfg_max_hits;
        bit [DUR_W-1:0]      cfg_over_dur;
        bit [GRACE_W-1:0]    cfg_grace;

        bit [IN_TIME_W-1:0]  last_hit;
        bit [IN_TIME_W-1:0]  last_over;
        bit [OVER_CNT_W-1:0] over_run;
        bit [HITS_W-1:0]     hit_count;
        bit                  latched;

        bit                  alarm_due[$];
        int                  errors;

        function new();
            cfg_max_hits = MAX_HITS_RST;
            cfg_over_dur = DUR_RST;
            cfg_grace    = GRACE_RST;
            clear_counts();
            latched      = 1'b0;
            errors       = 0;
        endfunction

        function void clear_counts();
            last_hit  = '0;
            last_over = '0;
            over_run  = '0;
            hit_count = '0;
        endfunction

        function void set_reg(reg_idx_t idx, bit [31:0] value);
            case (idx)
                REG_MAX_HITS: cfg_max_hits = value[MAX_HITS_W-1:0];
                REG_OVER_DUR: cfg_over_dur = value[DUR_W-1:0];
                REG_GRACE:    cfg_grace    = value[GRACE_W-1:0];
                default:      ;
            endcase
        endfunction

        function int pending();
            return alarm_due.size();
        endfunction

        function void note_hit(bit [IN_TIME_W-1:0] t);
            bit [IN_TIME_W:0]   grace_sum;
            bit [IN_TIME_W-1:0] grace_end;
            // While latched, hits before the end of the hold-off only report
            // the alarm. The end of the hold-off clips at the top of the range.
            if (latched)
            begin
                grace_sum = {1'b0, last_over} + {17'd0, cfg_grace};
                grace_end = grace_sum[IN_TIME_W] ? '1 : grace_sum[IN_TIME_W-1:0];
                if (t < grace_end)
                begin
                    alarm_due.push_back(1'b1);
                    return;
                end
                latched = 1'b0;
            end
            // A forward step of more than one second, or into a new second after
            // a quiet one, starts over. After an over second only the hit count
            // restarts. A time that does not move forward stays in this second.
            if (t > last_hit)
            begin
                if (t - last_hit > 1)
                    clear_counts();
                else if (hit_count <= {8'd0, cfg_max_hits})
                    clear_counts();
                else
                    hit_count = '0;
            end
            if (hit_count != '1)
                hit_count++;
            last_hit = t;
            if (hit_count > {8'd0, cfg_max_hits} && last_over < t)
            begin
                if (over_run != '1)
                    over_run++;
                last_over = t;
                if (over_run > cfg_over_dur)
                    latched = 1'b1;
            end
            alarm_due.push_back(latched);
        endfunction

        function void check_alarm(bit [7:0] data);
            bit want;
            if (alarm_due.size() == 0)
            begin
                if (errors < 200)
                    $display("%0t: alarm transfer with no hit pending: expected none, got 0x%02h",
                             $time, data);
                errors++;
                return;
            end
            want = alarm_due.pop_front();
            if (data[0] != want)
            begin
                if (errors < 200)
                    $display("%0t: alarm mismatch: expected %0b, got %0b",
                             $time, want, data[0]);
                errors++;
            end
            if (data[7:1] != 7'd0)
            begin
                if (errors < 200)
                    $display("%0t: alarm tdata padding: expected 0x00, got 0x%02h",
                             $time, {data[7:1], 1'b0});
                errors++;
            end
        endfunction
    endclass

    // Receiver stall patterns, one picked per stretch of cycles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    // Input stream: tdata[31:0] = hit_time_seconds.
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TIME_W-1:0]   s_axis_tdata = '0;

    // Output stream: tdata[0] = alarm, tdata[7:1] = zero.
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    alarm_scoreboard        sb;

    // Sender burst bookkeeping. sender_live is set while tvalid is held high
    // from one transfer into the next.
    int                     burst_left = 0;
    bit                     sender_live = 1'b0;

    // Receiver bookkeeping, owned by the receiver process alone.
    int                     rx_cycle = 0;
    int                     rx_seg_left = 0;
    int                     rx_hold_left = 0;
    rx_mode_t               rx_mode = RX_OPEN;

    hit_rate_threshold_alarm_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, where the inputs driven
    // at the falling edge are stable. The result check comes first; the hit
    // accepted at the same edge belongs to a later result anyway.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_alarm(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_hit(s_axis_tdata);
        end
    end

    // Receiver. It changes its stall pattern at random intervals: always ready,
    // a coin toss, ready with a one-in-four chance, or a steady toggle. It also
    // holds tready low periodically, long enough for the output and input
    // registers to fill and for s_axis_tready to drop while the sender keeps
    // offering hits.
    always @(negedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_cycle % 3000 == 1500)
        begin
            rx_hold_left = 59;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_seg_left == 0)
            begin
                rx_seg_left = $urandom_range(16, 160);
                rx_mode     = rx_mode_t'($urandom_range(0, 3));
            end
            rx_seg_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= $urandom_range(0, 1) == 1;
                RX_SPARSE: m_axis_tready <= $urandom_range(0, 3) == 0;
                default:   m_axis_tready <= rx_cycle[1];
            endcase
        end
        rx_cycle++;
    end

    // Offers one hit and returns at the falling edge after its transfer.
    // Hits go out in bursts of random length; after most bursts tvalid drops
    // for a random gap, after the rest the next burst follows directly.
    task automatic send_hit(input logic [IN_TIME_W-1:0] t);
        if (burst_left == 0)
            burst_left = $urandom_range(1, 24);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        sender_live = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 3) != 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            sender_live = 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
    endtask

    // Stops the sender and waits until every queued alarm has been seen, plus
    // a margin of idle cycles. Registers are only written after this.
    task automatic drain_hits();
        if (sender_live)
        begin
            s_axis_tvalid <= 1'b0;
            sender_live = 1'b0;
        end
        burst_left = 0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // APB write (setup and access cycle), then for a real register a read
    // back of the stored value. Called at a falling edge with the block idle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        if (idx == REG_NONE)
        begin
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        else
        begin
            case (idx)
                REG_MAX_HITS: stored = {24'd0, value[MAX_HITS_W-1:0]};
                REG_OVER_DUR: stored = {24'd0, value[DUR_W-1:0]};
                default:      stored = {16'd0, value[GRACE_W-1:0]};
            endcase
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== stored)
            begin
                $display("%0t: register %s read back: expected 0x%08h, got 0x%08h",
                         $time, idx.name(), stored, prdata);
                sb.errors++;
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic set_limits(input logic [7:0] max_hits, input logic [7:0] over_dur,
                              input logic [15:0] grace);
        write_reg(REG_MAX_HITS, {24'd0, max_hits});
        write_reg(REG_OVER_DUR, {24'd0, over_dur});
        write_reg(REG_GRACE, {16'd0, grace});
    endtask

    // Random traffic. Most of it is well-formed: a handful of hits per second,
    // seconds one after the other, so that over seconds pile up into an alarm
    // and the hold-off gets exercised. The rest is noise: a hit at a random
    // time, a hit slightly in the past, or a silent jump forward.
    task automatic random_traffic(input int quota);
        logic [IN_TIME_W-1:0] t;
        int                   sent;
        int                   k;
        int                   roll;
        case ($urandom_range(0, 3))
            0:       t = $urandom_range(0, 50);
            1:       t = 32'hFFFF_FFFF - $urandom_range(0, 60);
            default: t = $urandom;
        endcase
        sent = 0;
        while (sent < quota)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
            begin
                if (sb.cfg_max_hits < 8)
                    k = $urandom_range(1, sb.cfg_max_hits + 3);
                else if ($urandom_range(0, 15) == 0)
                    k = sb.cfg_max_hits + 1 + $urandom_range(0, 1);
                else
                    k = $urandom_range(1, 4);
                repeat (k)
                    send_hit(t);
                sent += k;
                t = t + 1;
            end
            else if (roll < 86)
            begin
                send_hit($urandom);
                sent++;
            end
            else if (roll < 93)
            begin
                send_hit(t - $urandom_range(1, 4));
                sent++;
            end
            else
                t = t + $urandom_range(2, 40);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limits: no hits allowed, no over seconds needed, 60 s hold-off.
        // A hit at time zero can never open an over second; one second later
        // it does and the alarm latches. Hits inside the hold-off just report
        // it, the first hit at its end is counted again. A hit at the top of
        // the range clips the hold-off end, and a repeated top time does not
        // open a new over second.
        send_hit(32'd0);
        send_hit(32'd0);
        send_hit(32'd1);
        send_hit(32'd2);
        send_hit(32'd61);
        send_hit(32'd62);
        send_hit(32'd200);
        send_hit(32'hFFFF_FFFF);
        send_hit(32'hFFFF_FFFF);
        send_hit(32'd5);
        drain_hits();

        // A write to the unused address must change nothing.
        write_reg(REG_NONE, 32'h0000_00FF);
        set_limits(8'd2, 8'd1, 16'd3);
        send_hit(32'd10);
        send_hit(32'd10);
        send_hit(32'd10);
        send_hit(32'd11);
        send_hit(32'd11);
        send_hit(32'd11);
        send_hit(32'd12);
        send_hit(32'd13);
        send_hit(32'd14);
        send_hit(32'd15);
        send_hit(32'd15);
        send_hit(32'd15);
        send_hit(32'd14);
        send_hit(32'd16);
        drain_hits();

        // No hold-off at all: the alarm ends with the next hit.
        set_limits(8'd0, 8'd0, 16'd0);
        send_hit(32'd100);
        send_hit(32'd100);
        drain_hits();

        // Longest hold-off, ending past the top of the time range.
        write_reg(REG_GRACE, 32'h0000_FFFF);
        send_hit(32'hFFFF_FFF0);
        send_hit(32'hFFFF_FFF1);
        send_hit(32'hFFFF_FFFF);
        drain_hits();

        // Over-second counter at its ceiling: 258 over seconds in a row with
        // the alarm out of reach, then the threshold is lowered to 254. Only a
        // counter that stopped at 255 raises the alarm on the next over second.
        set_limits(8'd0, 8'd255, 16'd0);
        send_hit(32'hFFFF_FFFF);
        send_hit(32'd0);
        for (int s = 2; s < 260; s++)
            send_hit(s);
        drain_hits();
        write_reg(REG_OVER_DUR, 32'd254);
        send_hit(32'd260);
        drain_hits();

        // Random phases; the first few pin the limits to fixed values, some of them extremes.
        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0:       set_limits(8'd0, 8'd0, 16'd0);
                1:       set_limits(8'd1, 8'd2, 16'd5);
                2:       set_limits(8'd255, 8'd0, 16'd3);
                3:       set_limits(8'd2, 8'd255, 16'hFFFF);
                4:       set_limits(8'd3, 8'd1, 16'd1);
                5:       set_limits(8'($urandom), 8'($urandom), 16'($urandom));
                default: set_limits(8'($urandom_range(0, 4)), 8'($urandom_range(0, 5)),
                                    16'($urandom_range(0, 12)));
            endcase
            random_traffic(60);
            drain_hits();
        end

        repeat (8)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10ms;
        $display("testbench: errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/hrta_pkg.sv
hw/rtl/hrta_cfg.sv
hw/rtl/hrta_core.sv
hw/rtl/hit_rate_threshold_alarm_unit.sv
tb/testbench.sv
